// ----- rtl/tld_object_record_parser_assert.svh -----
// Assertion helpers for the checker file of the record parser.
`ifndef TLD_OBJECT_RECORD_PARSER_ASSERT_SVH
`define TLD_OBJECT_RECORD_PARSER_ASSERT_SVH

// Same-cycle implication, switched off while reset is high.
`define ORP_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("record parser check failed");

// Next-cycle implication, switched off while reset is high.
`define ORP_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("record parser check failed");

// Same-cycle implication that also holds through reset.
`define ORP_ASSERT_ALL(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error("record parser check failed");

`endif

// ----- rtl/orp_pkg.sv -----
package orp_pkg;

  // Default depth of the result queue between the parser and the output stage.
  localparam int ORP_QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    KIND_CODE = 2'd0,
    KIND_FILL = 2'd1,
    KIND_END  = 2'd2,
    KIND_BAD  = 2'd3
  } kind_t;

  // One queued result: the kind and its raw value (byte, tag or signed size).
  typedef struct packed {
    kind_t       kind;
    logic [31:0] value;
  } entry_t;

endpackage

// ----- rtl/orp_in_if.sv -----
interface orp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       first_of_file;

  modport source (output valid, output byte_value, output first_of_file, input ready);
  modport sink (input valid, input byte_value, input first_of_file, output ready);
endinterface

// ----- rtl/orp_out_if.sv -----
interface orp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  code_byte;
  logic [30:0] fill_count;

  modport source (output valid, output kind, output code_byte, output fill_count,
                  input ready);
  modport sink (input valid, input kind, input code_byte, input fill_count,
                output ready);
endinterface

// ----- rtl/tld_object_record_parser.sv -----
// Object record parser: walks a tagged object file one byte per word on the
// input channel (byte_value, first_of_file) and gives zero or one result word
// per input byte on the output channel (kind, code_byte, fill_count).
// Code record payload bytes come out as kind 0, each storage record as one
// kind 1 fill run, an end record as kind 2 and an unknown tag as kind 3; after
// the last two the parser ignores bytes until one arrives with first_of_file.
// Throughput is one byte per cycle while the queue is not full: the record
// state machine in the front end updates in the cycle a byte is accepted.
// The accepting edge writes the result into the queue, and the output
// register loads it from the queue once the register is empty or its word is taken.
// Reset leaves the parser stopped, so it waits for a first-of-file byte; the
// queue and output register come up empty. When the receiver stalls, the
// output word holds, the queue fills, and input ready drops once the queue is
// full; bytes that cause no result also wait then.
module tld_object_record_parser
  import orp_pkg::*;
#(
  parameter int QUEUE_DEPTH = ORP_QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  orp_in_if.sink    bytes,
  orp_out_if.source records
);

  logic   q_push;
  logic   q_full;
  logic   q_pop;
  logic   q_nonempty;
  entry_t q_in;
  entry_t q_out;

  // Front end: record state machine, classifies each byte.
  orp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .bytes      (bytes),
    .full       (q_full),
    .push       (q_push),
    .push_entry (q_in)
  );

  // Short queue so the parser keeps taking bytes while the output is stalled.
  orp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .nonempty   (q_nonempty),
    .pop_entry  (q_out)
  );

  // Back end: formats results into the output register.
  orp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .nonempty  (q_nonempty),
    .pop_entry (q_out),
    .pop       (q_pop),
    .records   (records)
  );

endmodule

// ----- rtl/orp_queue.sv -----
module orp_queue
  import orp_pkg::*;
#(
  parameter int DEPTH = ORP_QUEUE_DEPTH
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  output logic   full,
  input  logic   pop,
  output logic   nonempty,
  output entry_t pop_entry
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t             slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full      = (count == CNT_W'(DEPTH));
  assign nonempty  = (count != '0);
  assign pop_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ----- rtl/orp_front.sv -----
module orp_front
  import orp_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  orp_in_if.sink   bytes,
  input  logic     full,
  output logic     push,
  output entry_t   push_entry
);

  typedef enum logic [5:0] {
    PH_TAG      = 6'b000001,
    PH_SKIP     = 6'b000010,
    PH_DATA_HDR = 6'b000100,
    PH_DATA     = 6'b001000,
    PH_FILL_HDR = 6'b010000,
    PH_DBG_HDR  = 6'b100000
  } phase_t;

  localparam logic [7:0] TAG_SHORT_A = 8'd1;
  localparam logic [7:0] TAG_SHORT_B = 8'd2;
  localparam logic [7:0] TAG_SHORT_C = 8'd3;
  localparam logic [7:0] TAG_END     = 8'd5;
  localparam logic [7:0] TAG_CODE    = 8'd10;
  localparam logic [7:0] TAG_FILL    = 8'd15;
  localparam logic [7:0] TAG_LONG_A  = 8'd22;
  localparam logic [7:0] TAG_LONG_B  = 8'd23;
  localparam logic [7:0] TAG_LONG_C  = 8'd24;
  localparam logic [7:0] TAG_DEBUG   = 8'd25;

  // Header lengths after the tag: line and size, line and size, full debug header.
  localparam logic [3:0] CODE_HDR_LEN  = 4'd4;
  localparam logic [3:0] FILL_HDR_LEN  = 4'd6;
  localparam logic [3:0] DEBUG_HDR_LEN = 4'd8;

  phase_t      phase, phase_next;
  logic [3:0]  field_index, field_index_next;
  logic [31:0] field_accumulator, field_accumulator_next;
  logic [15:0] bytes_remaining, bytes_remaining_next;
  logic        stopped, stopped_next;

  logic        accept;
  logic        emit;
  phase_t      ph;
  logic [3:0]  idx;
  logic [31:0] acc;
  logic [15:0] rem;
  logic [31:0] acc_sh;
  logic [3:0]  idx_inc;
  logic [15:0] rem_dec;
  logic [7:0]  b;

  assign bytes.ready = !full;
  assign accept      = bytes.valid && !full;
  assign push        = accept && emit;

  always_comb begin
    b   = bytes.byte_value;
    ph  = phase;
    idx = field_index;
    acc = field_accumulator;
    rem = bytes_remaining;
    stopped_next = stopped;
    // A first byte of a file drops whatever record was in progress.
    if (bytes.first_of_file) begin
      stopped_next = 1'b0;
      ph  = PH_TAG;
      idx = '0;
      acc = '0;
      rem = '0;
    end
    acc_sh  = {b, acc[31:8]};
    idx_inc = idx + 4'd1;
    rem_dec = rem - 16'd1;

    phase_next             = ph;
    field_index_next       = idx;
    field_accumulator_next = acc;
    bytes_remaining_next   = rem;
    emit                   = 1'b0;
    push_entry.kind        = KIND_CODE;
    push_entry.value       = '0;

    if (!stopped_next) begin
      unique case (ph)
        PH_SKIP: begin
          bytes_remaining_next = rem_dec;
          if (rem_dec == '0) begin
            phase_next = PH_TAG;
          end
        end
        PH_DATA_HDR: begin
          field_accumulator_next = acc_sh;
          field_index_next       = idx_inc;
          if (idx_inc >= CODE_HDR_LEN) begin
            bytes_remaining_next = acc_sh[31:16];
            phase_next = (acc_sh[31:16] != '0) ? PH_DATA : PH_TAG;
          end
        end
        PH_DATA: begin
          bytes_remaining_next = rem_dec;
          if (rem_dec == '0) begin
            phase_next = PH_TAG;
          end
          emit             = 1'b1;
          push_entry.kind  = KIND_CODE;
          push_entry.value = {24'd0, b};
        end
        PH_FILL_HDR: begin
          field_accumulator_next = acc_sh;
          field_index_next       = idx_inc;
          if (idx_inc >= FILL_HDR_LEN) begin
            phase_next       = PH_TAG;
            emit             = 1'b1;
            push_entry.kind  = KIND_FILL;
            push_entry.value = acc_sh;
          end
        end
        PH_DBG_HDR: begin
          field_accumulator_next = acc_sh;
          field_index_next       = idx_inc;
          if (idx_inc >= DEBUG_HDR_LEN) begin
            bytes_remaining_next = acc_sh[31:16];
            phase_next = (acc_sh[31:16] != '0) ? PH_SKIP : PH_TAG;
          end
        end
        PH_TAG: begin
          unique case (b) inside
            TAG_SHORT_A, TAG_SHORT_B, TAG_SHORT_C: begin
              phase_next           = PH_SKIP;
              bytes_remaining_next = 16'd1;
            end
            TAG_LONG_A, TAG_LONG_B, TAG_LONG_C: begin
              phase_next           = PH_SKIP;
              bytes_remaining_next = 16'd4;
            end
            TAG_CODE: begin
              phase_next             = PH_DATA_HDR;
              field_index_next       = '0;
              field_accumulator_next = '0;
            end
            TAG_FILL: begin
              phase_next             = PH_FILL_HDR;
              field_index_next       = '0;
              field_accumulator_next = '0;
            end
            TAG_DEBUG: begin
              phase_next             = PH_DBG_HDR;
              field_index_next       = '0;
              field_accumulator_next = '0;
            end
            TAG_END: begin
              stopped_next    = 1'b1;
              phase_next      = PH_TAG;
              emit            = 1'b1;
              push_entry.kind = KIND_END;
            end
            default: begin
              stopped_next     = 1'b1;
              phase_next       = PH_TAG;
              emit             = 1'b1;
              push_entry.kind  = KIND_BAD;
              push_entry.value = {24'd0, b};
            end
          endcase
        end
        default: begin
          phase_next = PH_TAG;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_TAG;
      field_index       <= '0;
      field_accumulator <= '0;
      bytes_remaining   <= '0;
      stopped           <= 1'b1;
    end else if (accept) begin
      phase             <= phase_next;
      field_index       <= field_index_next;
      field_accumulator <= field_accumulator_next;
      bytes_remaining   <= bytes_remaining_next;
      stopped           <= stopped_next;
    end
  end

endmodule

// ----- rtl/orp_back.sv -----
module orp_back
  import orp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      nonempty,
  input  entry_t    pop_entry,
  output logic      pop,
  orp_out_if.source records
);

  logic [7:0]  code_byte_next;
  logic [30:0] fill_count_next;

  assign pop = nonempty && (!records.valid || records.ready);

  // Expand a queued entry into the result fields; negative fill sizes give zero.
  always_comb begin
    code_byte_next  = '0;
    fill_count_next = '0;
    case (pop_entry.kind) inside
      KIND_CODE, KIND_BAD: begin
        code_byte_next = pop_entry.value[7:0];
      end
      KIND_FILL: begin
        fill_count_next = pop_entry.value[31] ? '0 : pop_entry.value[30:0];
      end
      default: begin
        code_byte_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      records.valid <= 1'b0;
    end else if (pop) begin
      records.valid <= 1'b1;
    end else if (records.ready) begin
      records.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      records.kind       <= pop_entry.kind;
      records.code_byte  <= code_byte_next;
      records.fill_count <= fill_count_next;
    end
  end

endmodule

// ----- rtl/orp_checker.sv -----
`include "tld_object_record_parser_assert.svh"

module orp_checker
  import orp_pkg::*;
(
  input logic       clk,
  input logic       rst,
  orp_in_if.sink    bytes,
  orp_out_if.source records
);

  `ORP_ASSERT_NXT(a_valid_holds, clk, rst, records.valid && !records.ready, records.valid)
  `ORP_ASSERT_NXT(a_word_holds, clk, rst, records.valid && !records.ready, $stable(records.kind) && $stable(records.code_byte) && $stable(records.fill_count))
  `ORP_ASSERT_IMP(a_no_byte, clk, rst, records.valid && (records.kind == KIND_FILL || records.kind == KIND_END), records.code_byte == 8'd0)
  `ORP_ASSERT_IMP(a_fill_only, clk, rst, records.valid && records.kind != KIND_FILL, records.fill_count == 31'd0)
  `ORP_ASSERT_ALL(a_reset_clean, clk, $past(rst), !records.valid && bytes.ready)

endmodule

bind tld_object_record_parser orp_checker u_orp_checker (
  .clk     (clk),
  .rst     (rst),
  .bytes   (bytes),
  .records (records)
);
